[hw/rtl/las_pkg.sv]
// Shared types and constants for the LED animation sequencer.
// No dependencies.
package las_pkg;

    localparam int NUM_LEDS = 29;
    localparam int LEDS_W   = 29;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    typedef logic [NUM_LEDS-1:0] led_vec_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    typedef enum logic [1:0] {
        MODE_ALL_ON = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_THIRDS = 2'd2,
        MODE_DROP   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_MS      = 2'd0,
        REG_DROP_STEP_MS = 2'd1,
        REG_PAUSE_MS     = 2'd2
    } cfg_reg_t;

    localparam logic [1:0] STG_RUN   = 2'd0;
    localparam logic [1:0] STG_PAUSE = 2'd1;
    localparam logic [1:0] STG_CLEAR = 2'd2;

    localparam cfg_t STEP_MS_RST      = CFG_W'(50);
    localparam cfg_t DROP_STEP_MS_RST = CFG_W'(100);
    localparam cfg_t PAUSE_MS_RST     = CFG_W'(500);

    localparam idx_t IDX_LAST = IDX_W'(NUM_LEDS - 1);
    localparam idx_t IDX_TOP  = IDX_W'(NUM_LEDS - 2);

    localparam led_vec_t LED_ALL = '1;

    function automatic led_vec_t phase_mask(input int p);
        led_vec_t m;
        int       r;
        m = '0;
        r = 0;
        for (int k = 0; k < NUM_LEDS; k++) begin
            if (r == p) m[k] = 1'b1;
            r = (r == 2) ? 0 : r + 1;
        end
        return m;
    endfunction

    localparam led_vec_t PHASE0 = phase_mask(0);
    localparam led_vec_t PHASE1 = phase_mask(1);
    localparam led_vec_t PHASE2 = phase_mask(2);

endpackage

[hw/rtl/led_animation_sequencer.sv]
// LED animation sequencer top level: per-request state update and output register.
// Depends on las_pkg.
//
// Channel  | Dir | Handshake            | Payload
// s_       | in  | s_tvalid / s_tready  | s_tdata: tick[0], buttons_pressed[3:1]
// m_       | out | m_tvalid / m_tready  | m_tdata: leds[28:0], mode[30:29]
// cfg_     | in  | cfg_wr_en            | cfg_index, cfg_wdata
//
// One request per cycle while s_tready is high; its result is registered and shows in the cycle after acceptance.
// The state update is one combinational pass from the state registers to their next values.
// s_tready is high when the output register is empty or being drained this cycle.
// Synchronous active-low reset clears state, config to defaults, and the output valid.
module led_animation_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [las_pkg::S_DATA_W-1:0]  s_tdata,   // tick, buttons_pressed
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [las_pkg::M_DATA_W-1:0]  m_tdata,   // leds, mode
    input  logic                          cfg_wr_en,
    input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [las_pkg::CFG_W-1:0]     cfg_wdata
);
    import las_pkg::*;

    typedef struct packed {
        logic done;
        cnt_t cnt;
    } tmr_t;

    function automatic tmr_t timed(input logic tk, input cnt_t cnt, input cfg_t dur);
        tmr_t r;
        cnt_t d;
        cnt_t c;
        d = (dur == '0) ? CNT_W'(1) : dur;
        c = cnt + CNT_W'(1);
        if (!tk) begin
            r = '{done: 1'b0, cnt: cnt};
        end else if (c >= d) begin
            r = '{done: 1'b1, cnt: '0};
        end else begin
            r = '{done: 1'b0, cnt: c};
        end
        return r;
    endfunction

    cfg_t     step_ms_reg, drop_step_ms_reg, pause_ms_reg;
    mode_t    mode_reg, mode_next;
    led_vec_t led_reg, led_next;
    logic [1:0] stage_reg, stage_next;
    idx_t     outer_reg, outer_next;
    idx_t     inner_reg, inner_next;
    cnt_t     cnt_reg, cnt_next;
    logic     m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic       s_accept;
    logic       tick;
    logic [2:0] btn;
    tmr_t       tmr;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign tick     = s_tdata[0];
    assign btn      = s_tdata[3:1];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        mode_next  = mode_reg;
        led_next   = led_reg;
        stage_next = stage_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        cnt_next   = cnt_reg;
        tmr        = '{done: 1'b0, cnt: cnt_reg};
        if (btn != 3'd0) begin
            mode_next  = btn[0] ? MODE_FILL : (btn[1] ? MODE_THIRDS : MODE_DROP);
            led_next   = '0;
            stage_next = STG_RUN;
            outer_next = '0;
            inner_next = IDX_TOP;
            cnt_next   = '0;
        end else begin
            unique case (mode_reg)
                MODE_FILL: begin
                    if (stage_reg > STG_CLEAR || outer_reg > IDX_LAST) begin
                        stage_next = STG_RUN;
                        outer_next = '0;
                        inner_next = IDX_TOP;
                        cnt_next   = '0;
                    end
                    if (cnt_next == '0) begin
                        if (stage_next == STG_RUN) begin
                            led_next = (outer_next == '0) ? led_vec_t'(1)
                                     : (led_next | (led_vec_t'(1) << outer_next));
                        end else if (stage_next == STG_CLEAR) begin
                            led_next = led_next & ~(led_vec_t'(1) << outer_next);
                        end
                    end
                    tmr      = timed(tick, cnt_next, step_ms_reg);
                    cnt_next = tmr.cnt;
                    if (tmr.done) begin
                        if (stage_next == STG_PAUSE) begin
                            stage_next = STG_CLEAR;
                            outer_next = '0;
                        end else if (outer_next >= IDX_LAST) begin
                            stage_next = (stage_next == STG_RUN) ? STG_PAUSE : STG_RUN;
                            outer_next = '0;
                        end else begin
                            outer_next = outer_next + IDX_W'(1);
                        end
                    end
                end
                MODE_THIRDS: begin
                    if (outer_reg > IDX_W'(2)) begin
                        stage_next = STG_RUN;
                        outer_next = '0;
                        inner_next = IDX_TOP;
                        cnt_next   = '0;
                    end
                    if (cnt_next == '0) begin
                        case (outer_next[1:0])
                            2'd0:    led_next = PHASE0;
                            2'd1:    led_next = PHASE1;
                            default: led_next = PHASE2;
                        endcase
                    end
                    tmr      = timed(tick, cnt_next, step_ms_reg);
                    cnt_next = tmr.cnt;
                    if (tmr.done) begin
                        outer_next = (outer_next >= IDX_W'(2)) ? '0 : outer_next + IDX_W'(1);
                    end
                end
                MODE_DROP: begin
                    if (stage_reg > STG_PAUSE || outer_reg > IDX_TOP
                        || inner_reg > IDX_TOP || inner_reg < outer_reg) begin
                        stage_next = STG_RUN;
                        outer_next = '0;
                        inner_next = IDX_TOP;
                        cnt_next   = '0;
                    end
                    if (stage_next == STG_RUN) begin
                        if (cnt_next == '0) begin
                            if (outer_next == '0 && inner_next == IDX_TOP) led_next = '0;
                            led_next = led_next | (led_vec_t'(1) << inner_next);
                            led_next = led_next & ~(led_vec_t'(1) << (inner_next + IDX_W'(1)));
                        end
                        tmr      = timed(tick, cnt_next, drop_step_ms_reg);
                        cnt_next = tmr.cnt;
                        if (tmr.done) begin
                            if (inner_next <= outer_next) stage_next = STG_PAUSE;
                            else inner_next = inner_next - IDX_W'(1);
                        end
                    end else begin
                        tmr      = timed(tick, cnt_next, pause_ms_reg);
                        cnt_next = tmr.cnt;
                        if (tmr.done) begin
                            outer_next = (outer_next >= IDX_TOP) ? '0
                                       : outer_next + IDX_W'(1);
                            inner_next = IDX_TOP;
                            stage_next = STG_RUN;
                        end
                    end
                end
                default: begin
                    led_next = LED_ALL;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ms_reg      <= STEP_MS_RST;
            drop_step_ms_reg <= DROP_STEP_MS_RST;
            pause_ms_reg     <= PAUSE_MS_RST;
            mode_reg         <= MODE_ALL_ON;
            led_reg          <= '0;
            stage_reg        <= STG_RUN;
            outer_reg        <= '0;
            inner_reg        <= IDX_TOP;
            cnt_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_STEP_MS:      step_ms_reg      <= cfg_wdata;
                    REG_DROP_STEP_MS: drop_step_ms_reg <= cfg_wdata;
                    REG_PAUSE_MS:     pause_ms_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_accept) begin
                mode_reg     <= mode_next;
                led_reg      <= led_next;
                stage_reg    <= stage_next;
                outer_reg    <= outer_next;
                inner_reg    <= inner_next;
                cnt_reg      <= cnt_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {1'b0, mode_next, LEDS_W'(led_next)};
        end
    end

`ifndef NO_ASSERTIONS
    a_left_button: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tdata[1] |=>
            m_tvalid && m_tdata[30:29] == MODE_FILL && m_tdata[28:0] == '0)
        else $error("left button did not select fill mode with LEDs cleared");

    a_mode_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_ALL_ON |=> mode_reg != MODE_ALL_ON)
        else $error("mode returned to all-on without reset");

    a_thirds_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_THIRDS |-> outer_reg <= IDX_W'(2))
        else $error("thirds phase index out of range");
`endif

endmodule

[tb/sv/tb_led_animation_sequencer.sv]
`timescale 1ns / 100ps
// Self-checking testbench for led_animation_sequencer: random stream traffic with
// stalls on both sides, register writes between phases, checked by an in-bench predictor.
// Depends on las_pkg and the led_animation_sequencer RTL.
module tb_led_animation_sequencer;
    import las_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 20;

    // tick in bit 0, buttons in bits 3:1
    typedef struct packed {
        logic [2:0] btn;
        logic       tick;
    } req_t;

    typedef struct packed {
        led_vec_t leds;
        mode_t    mode;
    } anim_out_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    req_t      req_pending[$];
    anim_out_t leds_due[$];
    anim_out_t want;
    bit        quiet = 1'b0;
    bit        s_acc = 1'b0;
    int        s_gap = 0;
    int        m_stall = 0;
    int        errs = 0;
    int        n_reqs = 0;
    int        n_results = 0;
    int        idle_cycles = 0;

    // predictor state
    mode_t    anim_mode;
    led_vec_t anim_leds;
    logic [1:0] anim_stage;
    idx_t     anim_outer;
    idx_t     anim_inner;
    cnt_t     anim_ms;
    cfg_t     step_len;
    cfg_t     drop_len;
    cfg_t     pause_len;

    led_animation_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic led_vec_t led_bit(input int n);
        led_vec_t v;
        v = '0;
        if (n >= 0 && n < NUM_LEDS) v[n] = 1'b1;
        return v;
    endfunction

    function automatic led_vec_t third_lit(input int p);
        led_vec_t v;
        v = '0;
        for (int k = p; k < NUM_LEDS; k += 3) v[k] = 1'b1;
        return v;
    endfunction

    function automatic void restart_anim();
        anim_stage = STG_RUN;
        anim_outer = '0;
        anim_inner = idx_t'(NUM_LEDS - 2);
        anim_ms    = '0;
    endfunction

    function automatic void reset_model();
        step_len  = CFG_W'(50);
        drop_len  = CFG_W'(100);
        pause_len = CFG_W'(500);
        anim_mode = MODE_ALL_ON;
        anim_leds = '0;
        restart_anim();
    endfunction

    // one millisecond counted against a step length; 1 when the step is over
    function automatic bit ms_elapsed(input logic tick, input cfg_t len);
        cnt_t d;
        d = (len == '0) ? cnt_t'(1) : len;
        if (!tick) return 1'b0;
        anim_ms = anim_ms + 1'b1;
        if (anim_ms >= d) begin
            anim_ms = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void fill_step(input logic tick);
        if (anim_stage > STG_CLEAR || anim_outer >= NUM_LEDS) restart_anim();
        if (anim_ms == '0) begin
            if (anim_stage == STG_RUN)
                anim_leds = (anim_outer == '0) ? led_bit(0) : (anim_leds | led_bit(anim_outer));
            else if (anim_stage == STG_CLEAR)
                anim_leds = anim_leds & ~led_bit(anim_outer);
        end
        if (!ms_elapsed(tick, step_len)) return;
        if (anim_stage == STG_PAUSE) begin
            anim_stage = STG_CLEAR;
            anim_outer = '0;
        end else if (anim_outer >= NUM_LEDS - 1) begin
            anim_stage = (anim_stage == STG_RUN) ? STG_PAUSE : STG_RUN;
            anim_outer = '0;
        end else begin
            anim_outer = anim_outer + 1'b1;
        end
    endfunction

    function automatic void thirds_step(input logic tick);
        if (anim_outer > 2) restart_anim();
        if (anim_ms == '0) anim_leds = third_lit(anim_outer);
        if (ms_elapsed(tick, step_len))
            anim_outer = (anim_outer >= 2) ? idx_t'(0) : anim_outer + 1'b1;
    endfunction

    function automatic void drop_step(input logic tick);
        if (anim_stage > STG_PAUSE || anim_outer >= NUM_LEDS - 1
            || anim_inner > NUM_LEDS - 2 || anim_inner < anim_outer)
            restart_anim();
        if (anim_stage == STG_RUN) begin
            if (anim_ms == '0) begin
                if (anim_outer == '0 && anim_inner == NUM_LEDS - 2) anim_leds = '0;
                anim_leds = anim_leds | led_bit(anim_inner);
                anim_leds = anim_leds & ~led_bit(anim_inner + 1);
            end
            if (ms_elapsed(tick, drop_len)) begin
                if (anim_inner <= anim_outer) anim_stage = STG_PAUSE;
                else anim_inner = anim_inner - 1'b1;
            end
        end else if (ms_elapsed(tick, pause_len)) begin
            anim_outer = anim_outer + 1'b1;
            if (anim_outer >= NUM_LEDS - 1) anim_outer = '0;
            anim_inner = idx_t'(NUM_LEDS - 2);
            anim_stage = STG_RUN;
        end
    endfunction

    function automatic anim_out_t animate(input logic tick, input logic [2:0] btn);
        anim_out_t r;
        if (btn != 3'd0) begin
            anim_mode = btn[0] ? MODE_FILL : (btn[1] ? MODE_THIRDS : MODE_DROP);
            anim_leds = '0;
            restart_anim();
        end else begin
            case (anim_mode)
                MODE_FILL:   fill_step(tick);
                MODE_THIRDS: thirds_step(tick);
                MODE_DROP:   drop_step(tick);
                default:     anim_leds = '1;
            endcase
        end
        r.leds = anim_leds;
        r.mode = anim_mode;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_acc)) begin
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (req_pending.size() > 0) begin
                s_tdata  <= {{(S_DATA_W - 4){1'b0}}, req_pending.pop_front()};
                s_tvalid <= 1'b1;
                s_gap    <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result-side backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_stall > 0) begin
            m_tready <= 1'b0;
            m_stall <= m_stall - 1;
        end else begin
            m_tready <= 1'b1;
            m_stall <= pick_gap();
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        s_acc <= s_tvalid && s_tready;
        if (!aresetn) begin
            reset_model();
            leds_due.delete();
            idle_cycles <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_MS:      step_len  = cfg_wdata;
                    REG_DROP_STEP_MS: drop_len  = cfg_wdata;
                    REG_PAUSE_MS:     pause_len = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                n_results++;
                if (leds_due.size() == 0) begin
                    errs++;
                    if (errs <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: %h", $time, m_tdata);
                end else begin
                    want = leds_due.pop_front();
                    if (m_tdata[LEDS_W-1:0] !== want.leds) begin
                        errs++;
                        if (errs <= MAX_REPORTS)
                            $display("%0t: leds expected %h actual %h", $time, want.leds,
                                     m_tdata[LEDS_W-1:0]);
                    end
                    if (m_tdata[LEDS_W+1:LEDS_W] !== want.mode) begin
                        errs++;
                        if (errs <= MAX_REPORTS)
                            $display("%0t: mode expected %0d actual %0d", $time, want.mode,
                                     m_tdata[LEDS_W+1:LEDS_W]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_reqs++;
                leds_due.push_back(animate(s_tdata[0], s_tdata[3:1]));
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_t val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || s_tvalid || leds_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // random requests: mostly released buttons with dense ticks, now and then a press
    task automatic queue_random(input int n, input bit presses);
        req_t r;
        logic [2:0] held;
        int hold;
        held = 3'd0;
        hold = 0;
        for (int i = 0; i < n; i++) begin
            r.tick = ($urandom_range(0, 9) < 8);
            if (hold > 0) begin
                r.btn = held;
                hold--;
            end else if (presses && $urandom_range(0, 299) == 0) begin
                held  = 3'($urandom_range(1, 7));
                hold  = $urandom_range(0, 3);
                r.btn = held;
            end else begin
                r.btn = 3'd0;
            end
            req_pending.push_back(r);
        end
    endtask

    task automatic run_phase(input cfg_t st, input cfg_t dr, input cfg_t pa,
                             input logic [2:0] start_btn, input int n,
                             input bit calm, input bit presses);
        req_t r;
        wait_drained();
        write_reg(REG_STEP_MS, st);
        write_reg(REG_DROP_STEP_MS, dr);
        write_reg(REG_PAUSE_MS, pa);
        quiet = calm;
        if (start_btn != 3'd0) begin
            r.btn  = start_btn;
            r.tick = 1'b1;
            req_pending.push_back(r);
        end
        queue_random(n, presses);
    endtask

    task automatic push_req(input logic tick, input logic [2:0] btn);
        req_t r;
        r.tick = tick;
        r.btn  = btn;
        req_pending.push_back(r);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all-on mode from reset, every button combination, held buttons
        push_req(1'b0, 3'd0);
        push_req(1'b1, 3'd0);
        push_req(1'b1, 3'd0);
        for (int b = 7; b >= 1; b--) begin
            push_req(1'b1, 3'(b));
            push_req(1'b0, 3'(b));
        end
        push_req(1'b0, 3'd1);
        for (int i = 0; i < 6; i++) push_req(1'(i % 2), 3'd0);

        run_phase(12'd1, 12'd1, 12'd1, 3'd4, 600, 1'b0, 1'b0);
        run_phase(12'd1, 12'd1, 12'd1, 3'd1, 150, 1'b1, 1'b1);
        run_phase(12'd0, 12'd0, 12'd0, 3'd2, 120, 1'b0, 1'b1);
        run_phase(12'd2, 12'd1, 12'd2, 3'd1, 200, 1'b0, 1'b1);
        wait_drained();
        write_reg(REG_UNUSED, cfg_t'($urandom_range(0, 4095)));
        run_phase(12'd4095, 12'd4095, 12'd4095, 3'd4, 60, 1'b0, 1'b0);
        // short durations with the counter left high by the long settings
        run_phase(12'd3, 12'd1, 12'd2, 3'd0, 150, 1'b0, 1'b1);
        run_phase(cfg_t'($urandom_range(1, 4)), cfg_t'($urandom_range(1, 4)),
                  cfg_t'($urandom_range(1, 4)), 3'($urandom_range(1, 7)), 250, 1'b0, 1'b1);

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("tb: %0d requests sent, %0d results checked, %0d mismatches", n_reqs,
                 n_results, errs);
        $display("tb: all four modes, button priority, step lengths 0 to 4095");
        if (errs == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
